// ===== rtl/core/tta_pkg.sv =====
// shared types, constants and register map of the telemetry threshold alarm
// no dependencies; every other file of the block but tta_ram uses this package
package tta_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  localparam int CH_W      = 4;
  localparam int VAL_W     = 16;
  localparam int COND_W    = 2;
  localparam int DELAY_W   = 8;
  localparam int REPEAT_W  = 10;
  localparam int COUNT_W   = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [DELAY_W-1:0]  WARN_DELAY_RST = 8'd150;
  localparam logic [REPEAT_W-1:0] REPEAT_RST     = 10'd250;
  localparam logic [COUNT_W-1:0]  COUNT_MAX      = 8'hFF;

  // truncating divide of a 31-bit magnitude by 100: (mag * DIV_MAGIC) >> DIV_SHIFT
  localparam int PROD_W  = 2 * VAL_W;
  localparam int MAG_W   = PROD_W - 1;
  localparam int MAGIC_W = 32;
  localparam int MUL_W   = MAG_W + MAGIC_W;
  localparam int DIV_SHIFT = 38;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 32'd2748779070;
  localparam int QUOT_W  = MUL_W - DIV_SHIFT;
  localparam int SCALED_W = QUOT_W + 1;
  localparam int SUM_W   = SCALED_W + 1;

  typedef enum logic [COND_W-1:0] {
    COND_NONE = 2'd0,
    COND_GT   = 2'd1,
    COND_LT   = 2'd2
  } cond_t;

  // register index taken from paddr[2]
  typedef enum logic {
    REG_WARN_DELAY = 1'b0,
    REG_REPEAT     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [DELAY_W-1:0]  warn_delay;
    logic [REPEAT_W-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] raw_value;
    logic                    no_data;
    logic signed [VAL_W-1:0] scale_percent;
    logic signed [VAL_W-1:0] value_offset;
    logic signed [VAL_W-1:0] alarm_threshold;
    logic [COND_W-1:0]       alarm_condition;
    logic                    mute;
    logic                    last_of_tick;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] channel_out;
    logic            alarm_now;
    logic            warning_on;
    logic            any_warning;
    logic            play_warning;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               warn;
  } entry_t;

  typedef struct packed {
    logic            rd_en;
    logic [CH_W-1:0] rd_ch;
    logic            wr_en;
    logic [CH_W-1:0] wr_ch;
    logic            alarm;
  } persist_req_t;

  typedef struct packed {
    logic warn_on;
    logic any_warn;
  } persist_res_t;

endpackage

// ===== rtl/core/tta_if.sv =====
// item channels of the telemetry threshold alarm: sample in, result out
// depends on tta_pkg for field widths
interface tta_in_if;
  logic                             valid;
  logic                             ready;
  logic [tta_pkg::CH_W-1:0]         channel;
  logic signed [tta_pkg::VAL_W-1:0] raw_value;
  logic                             no_data;
  logic signed [tta_pkg::VAL_W-1:0] scale_percent;
  logic signed [tta_pkg::VAL_W-1:0] value_offset;
  logic signed [tta_pkg::VAL_W-1:0] alarm_threshold;
  logic [tta_pkg::COND_W-1:0]       alarm_condition;
  logic                             mute;
  logic                             last_of_tick;

  modport source (output valid, channel, raw_value, no_data, scale_percent, value_offset,
                  alarm_threshold, alarm_condition, mute, last_of_tick, input ready);
  modport sink   (input valid, channel, raw_value, no_data, scale_percent, value_offset,
                  alarm_threshold, alarm_condition, mute, last_of_tick, output ready);
endinterface

interface tta_out_if;
  logic                     valid;
  logic                     ready;
  logic [tta_pkg::CH_W-1:0] channel_out;
  logic                     alarm_now;
  logic                     warning_on;
  logic                     any_warning;
  logic                     play_warning;

  modport source (output valid, channel_out, alarm_now, warning_on, any_warning,
                  play_warning, input ready);
  modport sink   (input valid, channel_out, alarm_now, warning_on, any_warning,
                  play_warning, output ready);
endinterface

// ===== rtl/core/tta_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies; read data holds while the read enable is low
module tta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tta_cfg.sv =====
// apb-style register file: warning delay and repeat period
// depends on tta_pkg for the register map and reset values
module tta_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tta_pkg::PADDR_W-1:0]   paddr,
  input  logic [tta_pkg::PDATA_W-1:0]   pwdata,
  output logic [tta_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output tta_pkg::cfg_t                 cfg
);
  import tta_pkg::*;

  logic [DELAY_W-1:0]  warn_delay_r;
  logic [REPEAT_W-1:0] repeat_r;
  reg_idx_t            idx;
  logic                wr_go;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_go  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_delay_r <= WARN_DELAY_RST;
      repeat_r     <= REPEAT_RST;
    end else if (wr_go) begin
      unique case (idx)
        REG_WARN_DELAY: warn_delay_r <= pwdata[DELAY_W-1:0];
        REG_REPEAT:     repeat_r     <= pwdata[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WARN_DELAY: prdata = PDATA_W'(warn_delay_r);
      REG_REPEAT:     prdata = PDATA_W'(repeat_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg.warn_delay   = warn_delay_r;
  assign cfg.repeat_ticks = repeat_r;

endmodule

// ===== rtl/core/tta_scale.sv =====
// two-stage scaling datapath: raw * percent, then truncating divide by 100
// via a reciprocal multiply; depends on tta_pkg
module tta_scale (
  input  logic                                 clk,
  input  logic                                 en1,
  input  logic                                 en2,
  input  logic signed [tta_pkg::VAL_W-1:0]     raw_value,
  input  logic signed [tta_pkg::VAL_W-1:0]     scale_percent,
  output logic signed [tta_pkg::SCALED_W-1:0]  scaled
);
  import tta_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]         mag;
  logic [MUL_W-1:0]         mul_r;
  logic                     neg_r;
  logic [QUOT_W-1:0]        quot;

  // magnitude never exceeds 2^30, so it fits the lower bits
  assign mag = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);

  always_ff @(posedge clk) begin
    if (en1) begin
      prod_r <= PROD_W'(raw_value) * PROD_W'(scale_percent);
    end
    if (en2) begin
      neg_r <= prod_r[PROD_W-1];
      mul_r <= MUL_W'(mag) * MUL_W'(DIV_MAGIC);
    end
  end

  assign quot   = mul_r[MUL_W-1:DIV_SHIFT];
  assign scaled = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

// ===== rtl/core/tta_persist.sv =====
// per-channel persistence counters and warning flags held in one ram,
// read-modify-write with forwarding; depends on tta_pkg and tta_ram
module tta_persist #(
  parameter int NUM_CHANNELS = tta_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tta_pkg::persist_req_t        req,
  input  logic [tta_pkg::DELAY_W-1:0]  warn_delay,
  output tta_pkg::persist_res_t        res
);
  import tta_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW = $clog2(NUM_CHANNELS + 1);
  localparam int EW = $bits(entry_t);

  logic [AW-1:0]           rd_addr, wr_addr;
  logic                    wr_in_range, wr_go;
  logic [EW-1:0]           ram_rdata;
  entry_t                  cur, upd, fwd_data_r;
  logic                    fwd_hit_r, rd_valid_r;
  logic [NUM_CHANNELS-1:0] valid_r;
  logic [CW-1:0]           wcnt_r, wcnt_nxt;
  logic                    set_w, clr_w;

  assign rd_addr     = AW'(req.rd_ch);
  assign wr_addr     = AW'(req.wr_ch);
  assign wr_in_range = 32'(req.wr_ch) < 32'(NUM_CHANNELS);
  assign wr_go       = req.wr_en && wr_in_range;

  tta_ram #(.WIDTH(EW), .DEPTH(NUM_CHANNELS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (wr_go),
    .waddr (wr_addr),
    .wdata (upd),
    .re    (req.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // a write landing on the same edge as the read is caught here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r  <= 1'b0;
      rd_valid_r <= 1'b0;
      valid_r    <= '0;
      wcnt_r     <= '0;
    end else begin
      if (req.rd_en) begin
        fwd_hit_r  <= wr_go && (wr_addr == rd_addr);
        rd_valid_r <= valid_r[rd_addr];
      end
      if (wr_go) begin
        valid_r[wr_addr] <= 1'b1;
      end
      wcnt_r <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      fwd_data_r <= upd;
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      cur = fwd_data_r;
    end else if (rd_valid_r) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    upd = cur;
    if (req.alarm) begin
      if (!cur.warn && cur.count != COUNT_MAX) begin
        upd.count = cur.count + COUNT_W'(1);
      end
    end else begin
      if (cur.count != '0) begin
        upd.count = cur.count - COUNT_W'(1);
      end
      if (upd.count == '0) begin
        upd.warn = 1'b0;
      end
    end
    if (upd.count > warn_delay && !upd.warn) begin
      upd.warn = 1'b1;
    end
  end

  // running number of channels whose flag is set
  assign set_w    = wr_go && upd.warn && !cur.warn;
  assign clr_w    = wr_go && !upd.warn && cur.warn;
  assign wcnt_nxt = wcnt_r + CW'(set_w) - CW'(clr_w);

  assign res.warn_on  = wr_in_range && upd.warn;
  assign res.any_warn = wcnt_nxt != '0;

endmodule

// ===== rtl/core/telemetry_threshold_alarm_top.sv =====
// Telemetry threshold alarm, top level.
// Input channel in_if carries one telemetry sample per item; out_if returns
// exactly one result item per sample, in order: the channel, its
// instantaneous alarm, its persistent warning flag and, on the item that
// ends a tick, the any-warning summary and the sound request.
// Configuration (warning delay, repeat period) is written over the APB-style
// port at byte addresses 0 and 4; the user writes it only while no item
// is in flight, which the block does not enforce. Stages: product, then
// reciprocal divide with the counter ram read, then compare, counter update
// and output register. Throughput: one item per cycle while out_if.ready
// stays high; the counter ram has one read and one write port and a
// forwarding register covers back-to-back samples of one channel.
// Reset (synchronous, rst_n low) empties the pipeline, restores register
// defaults and clears all counters, warning flags and the repeat phase; the
// counter ram is cleared by per-entry valid bits, so no clearing pass runs.
// When the receiver holds ready low the output item waits and the two
// stages behind it keep filling, so up to three items sit inside before
// in_if.ready drops.
module telemetry_threshold_alarm_top #(
  parameter int NUM_CHANNELS = tta_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tta_in_if.sink                       in_if,
  tta_out_if.source                    out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tta_pkg::PADDR_W-1:0]  paddr,
  input  logic [tta_pkg::PDATA_W-1:0]  pwdata,
  output logic [tta_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import tta_pkg::*;

  cfg_t                      cfg;
  in_item_t                  in_item, r1_r, r2_r;
  out_item_t                 out_r;
  logic                      v1_r, v2_r, ov_r;
  logic                      v1_nxt, v2_nxt, ov_nxt;
  logic                      en1, en2, en_out, in_ready;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SUM_W-1:0]   value_s;
  logic                      alarm;
  persist_req_t              preq;
  persist_res_t              pres;
  logic                      active_r;
  logic [REPEAT_W-1:0]       phase_r, phase_nxt;
  logic [REPEAT_W-1:0]       period, phase_base;
  logic [REPEAT_W:0]         phase_inc;
  logic                      play;

  tta_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_item.channel         = in_if.channel;
  assign in_item.raw_value       = in_if.raw_value;
  assign in_item.no_data         = in_if.no_data;
  assign in_item.scale_percent   = in_if.scale_percent;
  assign in_item.value_offset    = in_if.value_offset;
  assign in_item.alarm_threshold = in_if.alarm_threshold;
  assign in_item.alarm_condition = in_if.alarm_condition;
  assign in_item.mute            = in_if.mute;
  assign in_item.last_of_tick    = in_if.last_of_tick;

  // stage enables: each stage moves when the one ahead is empty or moving
  assign en_out   = v2_r && (!ov_r || out_if.ready);
  assign en2      = v1_r && (!v2_r || en_out);
  assign in_ready = !v1_r || en2;
  assign en1      = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  assign v1_nxt = en1 || (v1_r && !en2);
  assign v2_nxt = en2 || (v2_r && !en_out);
  assign ov_nxt = en_out || (ov_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      r1_r <= in_item;
    end
    if (en2) begin
      r2_r <= r1_r;
    end
  end

  tta_scale u_scale (
    .clk           (clk),
    .en1           (en1),
    .en2           (en2),
    .raw_value     (in_item.raw_value),
    .scale_percent (in_item.scale_percent),
    .scaled        (scaled)
  );

  assign value_s = SUM_W'(scaled) + SUM_W'(r2_r.value_offset);

  always_comb begin
    alarm = 1'b0;
    if (!r2_r.no_data) begin
      case (r2_r.alarm_condition)
        COND_GT: alarm = value_s > SUM_W'(r2_r.alarm_threshold);
        COND_LT: alarm = value_s < SUM_W'(r2_r.alarm_threshold);
        default: alarm = 1'b0;
      endcase
    end
  end

  assign preq.rd_en = en2;
  assign preq.rd_ch = r1_r.channel;
  assign preq.wr_en = en_out;
  assign preq.wr_ch = r2_r.channel;
  assign preq.alarm = alarm;

  tta_persist #(.NUM_CHANNELS(NUM_CHANNELS)) u_persist (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (preq),
    .warn_delay (cfg.warn_delay),
    .res        (pres)
  );

  // repeat phase of the warning sound, advanced once per tick end
  assign period     = (cfg.repeat_ticks == '0) ? REPEAT_W'(1) : cfg.repeat_ticks;
  assign phase_base = (!active_r || phase_r >= period) ? '0 : phase_r;
  assign phase_inc  = (REPEAT_W + 1)'(phase_base) + (REPEAT_W + 1)'(1);

  always_comb begin
    if (pres.any_warn) begin
      play      = (phase_base == '0) && !r2_r.mute;
      phase_nxt = (phase_inc >= (REPEAT_W + 1)'(period)) ? '0 : phase_inc[REPEAT_W-1:0];
    end else begin
      play      = 1'b0;
      phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= '0;
    end else if (en_out && r2_r.last_of_tick) begin
      active_r <= pres.any_warn;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_r.channel_out  <= r2_r.channel;
      out_r.alarm_now    <= alarm;
      out_r.warning_on   <= pres.warn_on;
      out_r.any_warning  <= r2_r.last_of_tick && pres.any_warn;
      out_r.play_warning <= r2_r.last_of_tick && play;
    end
  end

  assign out_if.valid        = ov_r;
  assign out_if.channel_out  = out_r.channel_out;
  assign out_if.alarm_now    = out_r.alarm_now;
  assign out_if.warning_on   = out_r.warning_on;
  assign out_if.any_warning  = out_r.any_warning;
  assign out_if.play_warning = out_r.play_warning;

endmodule

// ===== rtl/core/tta_checker.sv =====
// port-level checks of the telemetry threshold alarm and their bind
// depends on tta_pkg and on the top level's ports
module tta_checker #(
  parameter int NUM_CHANNELS = tta_pkg::NUM_CHANNELS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [tta_pkg::CH_W-1:0] channel_out,
  input logic                     alarm_now,
  input logic                     warning_on,
  input logic                     any_warning,
  input logic                     play_warning
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({channel_out, alarm_now, warning_on, any_warning, play_warning}))
    else $error("result item changed while stalled");

  // a sound request only comes with a warning present
  a_play_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && play_warning |-> any_warning)
    else $error("play_warning without any_warning");

  // channels past the configured count never warn
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (32'(channel_out) >= 32'(NUM_CHANNELS)) |-> !warning_on)
    else $error("warning on a channel beyond the channel count");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind telemetry_threshold_alarm_top tta_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_tta_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .channel_out  (out_if.channel_out),
  .alarm_now    (out_if.alarm_now),
  .warning_on   (out_if.warning_on),
  .any_warning  (out_if.any_warning),
  .play_warning (out_if.play_warning)
);
